>>> sv/unique_random_index_drawer_macros.svh
// Assertion macros shared by the unique random index drawer RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef UNIQUE_RANDOM_INDEX_DRAWER_MACROS_SVH
`define UNIQUE_RANDOM_INDEX_DRAWER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define URID_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urid assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define URID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urid assertion failed");

`endif

>>> sv/urid_pkg.sv
// Shared constants and controller/datapath interface types for the index drawer.
// No dependencies; the controller, datapath, top level and testbench refer to it by scoped names.
package urid_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int INDEX_W   = $clog2(MAX_ITEMS);
    localparam int COUNT_W   = INDEX_W + 1;
    localparam int WORD_W    = 32;
    localparam int DIV_STEPS = WORD_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cnt_clear;   // reset the shared step/address counter
        logic cnt_inc;     // advance the shared counter
        logic clr_write;   // write a zero into the bitmap at the counter address
        logic load_floor;  // load the divider with 2^32 - n
        logic load_word;   // load the divider with the incoming random word
        logic div_step;    // one restoring-division step
        logic floor_write; // store the finished remainder as the rejection floor
        logic ram_rd;      // read the bitmap at the candidate
        logic mark;        // mark the candidate, emit the result, bump the count
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;    // counter is at the last bitmap address
        logic div_last;    // counter is at the last division step
        logic drawn_done;  // all indices of this run have been emitted
        logic small_n;     // configured count is below two
        logic below_floor; // incoming word falls in the rejected range
        logic seen;        // bitmap read data for the candidate
        logic out_free;    // output register can take a result this cycle
    } dp_status_t;

endpackage

>>> sv/urid_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module urid_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/urid_ctrl.sv
// Controller state machine for the index drawer: clearing pass, floor
// computation, word acceptance, division and bitmap check. Uses urid_pkg.
module urid_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  urid_pkg::dp_status_t   sts,
    output urid_pkg::ctrl_cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_FLOOR = 3'd1;
    localparam logic [2:0] S_IDLE  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register; reset starts a clearing pass over the bitmap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.cnt_clear  = 1'b1;
                    cmd.load_floor = 1'b1;
                    state_next     = S_FLOOR;
                end
            end
            S_FLOOR:
            begin
                cmd.div_step = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (sts.div_last)
                begin
                    cmd.floor_write = 1'b1;
                    cmd.cnt_clear   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_word = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    // Finished runs and rejected words leave without a result.
                    if (sts.drawn_done)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.small_n)
                    begin
                        state_next = S_READ;
                    end
                    else if (sts.below_floor)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (sts.div_last)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                cmd.ram_rd = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // A repeated candidate is dropped; a new one waits for the output.
                if (sts.seen)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.mark   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // A count write restarts the run from a clearing pass and takes no word.
        if (cfg_wr)
        begin
            cmd        = '0;
            cmd.cnt_clear = 1'b1;
            in_ready   = 1'b0;
            state_next = S_CLEAR;
        end
    end

endmodule

>>> sv/urid_dp.sv
// Datapath for the index drawer: count and floor registers, bit-serial
// remainder unit, seen bitmap RAM and output register. Uses urid_pkg, urid_ram.
module urid_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr,
    input  logic [urid_pkg::COUNT_W-1:0]      range_count,
    input  logic [urid_pkg::WORD_W-1:0]       random_word,
    input  urid_pkg::ctrl_cmd_t               cmd,
    output urid_pkg::dp_status_t              sts,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [urid_pkg::INDEX_W-1:0]      index_value,
    output logic [urid_pkg::INDEX_W-1:0]      position,
    output logic                              is_last
);

    logic [urid_pkg::COUNT_W-1:0] range_reg;
    logic [urid_pkg::COUNT_W-1:0] drawn_reg;
    logic [urid_pkg::INDEX_W-1:0] floor_reg;
    logic [urid_pkg::INDEX_W-1:0] cnt_reg;
    logic [urid_pkg::WORD_W-1:0]  dvd_reg;
    logic [urid_pkg::COUNT_W-1:0] rem_reg;
    logic                         out_valid_reg;
    logic [urid_pkg::INDEX_W-1:0] index_reg;
    logic [urid_pkg::INDEX_W-1:0] position_reg;
    logic                         last_reg;

    logic [urid_pkg::COUNT_W-1:0] count_sat;
    logic [urid_pkg::COUNT_W:0]   rem_shift;
    logic [urid_pkg::COUNT_W:0]   range_ext;
    logic [urid_pkg::COUNT_W-1:0] rem_step;
    logic [urid_pkg::WORD_W-1:0]  floor_dvd;
    logic [urid_pkg::INDEX_W-1:0] cand;
    logic [urid_pkg::COUNT_W-1:0] drawn_inc;
    logic                         ram_we;
    logic [urid_pkg::INDEX_W-1:0] ram_waddr;
    logic                         ram_rdata;

    // Written counts above the bitmap size saturate.
    assign count_sat = (range_count > urid_pkg::COUNT_W'(urid_pkg::MAX_ITEMS))
                     ? urid_pkg::COUNT_W'(urid_pkg::MAX_ITEMS) : range_count;

    // One restoring-division step: shift in the next dividend bit, subtract if it fits.
    assign rem_shift = {rem_reg, dvd_reg[urid_pkg::WORD_W-1]};
    assign range_ext = {1'b0, range_reg};
    assign rem_step  = (rem_shift >= range_ext)
                     ? urid_pkg::COUNT_W'(rem_shift - range_ext)
                     : urid_pkg::COUNT_W'(rem_shift);

    // 2^32 - n in 32 bits; its remainder by n is the rejection floor.
    assign floor_dvd = urid_pkg::WORD_W'(0)
                     - {{(urid_pkg::WORD_W - urid_pkg::COUNT_W){1'b0}}, range_reg};

    assign cand      = rem_reg[urid_pkg::INDEX_W-1:0];
    assign drawn_inc = drawn_reg + urid_pkg::COUNT_W'(1);

    // Run state: count, drawn total and rejection floor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= '0;
            drawn_reg <= '0;
            floor_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                range_reg <= count_sat;
                drawn_reg <= '0;
            end
            else if (cmd.mark)
            begin
                drawn_reg <= drawn_inc;
            end
            if (cmd.floor_write)
            begin
                floor_reg <= sts.small_n ? '0 : rem_step[urid_pkg::INDEX_W-1:0];
            end
        end
    end

    // Shared counter for clearing addresses and division steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_clear)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + urid_pkg::INDEX_W'(1);
        end
    end

    // Remainder unit registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_floor)
        begin
            dvd_reg <= floor_dvd;
            rem_reg <= '0;
        end
        else if (cmd.load_word)
        begin
            dvd_reg <= random_word;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[urid_pkg::WORD_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    // Seen bitmap: cleared by the sweep, set when an index is drawn.
    assign ram_we    = cmd.clr_write | cmd.mark;
    assign ram_waddr = cmd.clr_write ? cnt_reg : cand;

    urid_ram #(
        .WIDTH (1),
        .DEPTH (urid_pkg::MAX_ITEMS)
    ) u_seen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.mark),
        .re    (cmd.ram_rd),
        .raddr (cand),
        .rdata (ram_rdata)
    );

    // Output register, loaded when a new index is drawn.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.mark)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark)
        begin
            index_reg    <= cand;
            position_reg <= drawn_reg[urid_pkg::INDEX_W-1:0];
            last_reg     <= (drawn_inc == range_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign index_value = index_reg;
    assign position    = position_reg;
    assign is_last     = last_reg;

    // Status toward the controller.
    always_comb
    begin
        sts.clr_last    = (cnt_reg == urid_pkg::INDEX_W'(urid_pkg::MAX_ITEMS - 1));
        sts.div_last    = (cnt_reg == urid_pkg::INDEX_W'(urid_pkg::DIV_STEPS - 1));
        sts.drawn_done  = (drawn_reg >= range_reg);
        sts.small_n     = (range_reg < urid_pkg::COUNT_W'(2));
        sts.below_floor = (random_word
                           < {{(urid_pkg::WORD_W - urid_pkg::INDEX_W){1'b0}}, floor_reg});
        sts.seen        = ram_rdata;
        sts.out_free    = !out_valid_reg || out_ready;
    end

endmodule

>>> sv/unique_random_index_drawer.sv
// Unique random index drawer: builds a random permutation of 0..n-1 from raw
// random words. Channels:
//   cfg   (cfg_valid/cfg_ready, range_count): sets n, saturated to 1024, and
//         starts a new run. cfg_ready is always high.
//   in    (in_valid/in_ready, random_word): one raw 32-bit random word per request.
//   out   (out_valid/out_ready, index_value, position, is_last): one new index.
// Each word is rejection-sampled, reduced mod n by a bit-serial remainder unit
// (one bit per cycle) unless n is below two, and checked against a seen bitmap RAM.
// Rejected, repeated and post-completion words produce no result.
// A word that goes through the divider passes the division, bitmap read and
// bitmap check states to the output register; with a count below two it skips
// the division. One word is in work at a time; the next is taken only in idle.
// After reset and after every count write, a clearing pass sweeps all 1024
// bitmap addresses and a division computes the rejection floor; in_ready
// stays low throughout both.
// The output register holds a result until taken; while the receiver stalls,
// the next word may still be accepted and divided, and it waits at the bitmap
// check until the output register is free.
// Depends on urid_pkg, urid_ctrl, urid_dp and the macros header.
`include "unique_random_index_drawer_macros.svh"

module unique_random_index_drawer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [urid_pkg::COUNT_W-1:0]      range_count,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [urid_pkg::WORD_W-1:0]       random_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [urid_pkg::INDEX_W-1:0]      index_value,
    output logic [urid_pkg::INDEX_W-1:0]      position,
    output logic                              is_last
);

    urid_pkg::ctrl_cmd_t  cmd;
    urid_pkg::dp_status_t sts;
    logic                 cfg_wr;

    // Count writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    urid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    urid_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_wr),
        .range_count (range_count),
        .random_word (random_word),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .index_value (index_value),
        .position    (position),
        .is_last     (is_last)
    );

    // A marked index was never seen in this run and the run was not complete.
    `URID_ASSERT_NOW(a_mark_unseen, cmd.mark, !sts.seen && !sts.drawn_done)
    // Marking always fills the output register on the next cycle.
    `URID_ASSERT_NEXT(a_mark_fills_out, cmd.mark, out_valid)
    // No word is taken while the bitmap is being cleared.
    `URID_ASSERT_NOW(a_clear_blocks_in, cmd.clr_write, !in_ready)
    // A result is only written when the output register can take it.
    `URID_ASSERT_NOW(a_mark_out_free, cmd.mark, !out_valid || out_ready)

endmodule

>>> dv/tb_unique_random_index_drawer.sv
`timescale 1ns / 100ps
// Self-checking testbench for unique_random_index_drawer: a bitmap predictor of the
// permutation forecasts every drawn index, and a scoreboard compares the output stream.
// Depends on urid_pkg and the drawer RTL only.

// One predicted draw, in the order the block should emit it.
typedef struct {
    logic [urid_pkg::INDEX_W-1:0] index_value;
    logic [urid_pkg::INDEX_W-1:0] position;
    logic                         is_last;
} drawn_index_t;

class perm_scoreboard;
    bit           seen_map [urid_pkg::MAX_ITEMS];
    int unsigned  draw_total;
    int unsigned  range_n;
    int unsigned  reject_floor;
    drawn_index_t pending_draws[$];
    int           mismatches;

    // A count write starts a new permutation with an empty bitmap.
    function void start_run(input logic [urid_pkg::COUNT_W-1:0] count);
        int unsigned n;
        n = (count > urid_pkg::MAX_ITEMS) ? urid_pkg::MAX_ITEMS : count;
        foreach (seen_map[i])
            seen_map[i] = 1'b0;
        draw_total = 0;
        range_n = n;
        // Words below 2^32 mod n would bias the low residues.
        reject_floor = (n < 2) ? 0 : (32'd0 - n) % n;
    endfunction

    function bit complete();
        return draw_total >= range_n;
    endfunction

    // Notes an accepted word. Returns 0 when the block ignores the word outright.
    function bit note_word(input logic [urid_pkg::WORD_W-1:0] word);
        int unsigned  cand;
        drawn_index_t draw;
        if (complete())
            return 1'b0;
        if (range_n < 2)
            cand = 0;
        else if (word < reject_floor)
            return 1'b1;
        else
            cand = word % range_n;
        if (seen_map[cand])
            return 1'b1;
        seen_map[cand] = 1'b1;
        draw.index_value = urid_pkg::INDEX_W'(cand);
        draw.position = urid_pkg::INDEX_W'(draw_total);
        draw.is_last = (draw_total + 1 == range_n);
        pending_draws.push_back(draw);
        draw_total++;
        return 1'b1;
    endfunction

    // Builds a word that lands on a not yet drawn index, with a random quotient.
    function logic [urid_pkg::WORD_W-1:0] fresh_word();
        int unsigned cand;
        int unsigned kmax;
        int unsigned tries;
        if (range_n < 2 || complete())
            return $urandom;
        cand = $urandom_range(range_n - 1, 0);
        for (tries = 0; tries < range_n && seen_map[cand]; tries++)
            cand = (cand + 1) % range_n;
        kmax = (32'hFFFF_FFFF - cand) / range_n;
        return $urandom_range(kmax, 0) * range_n + cand;
    endfunction

    // A word in the rejected band, or any word when the band is empty.
    function logic [urid_pkg::WORD_W-1:0] rejected_word();
        if (reject_floor == 0)
            return $urandom;
        return $urandom_range(reject_floor - 1, 0);
    endfunction

    task report(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Compares one emitted index with the oldest prediction.
    task check_draw(input logic [urid_pkg::INDEX_W-1:0] idx,
                    input logic [urid_pkg::INDEX_W-1:0] pos,
                    input logic last);
        drawn_index_t want;
        if (pending_draws.size() == 0) begin
            report($sformatf("unexpected index %0d at position %0d", idx, pos));
            return;
        end
        want = pending_draws.pop_front();
        if (idx !== want.index_value)
            report($sformatf("index_value %0d, predicted %0d", idx, want.index_value));
        if (pos !== want.position)
            report($sformatf("position %0d, predicted %0d", pos, want.position));
        if (last !== want.is_last)
            report($sformatf("is_last %0b, predicted %0b at position %0d",
                             last, want.is_last, want.position));
    endtask
endclass

module tb_unique_random_index_drawer;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 50;
    localparam int RANDOM_WORDS = 750;
    localparam int HOLD_CYCLES  = 400;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [urid_pkg::COUNT_W-1:0]    range_count = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [urid_pkg::WORD_W-1:0]     random_word = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [urid_pkg::INDEX_W-1:0]    index_value;
    logic [urid_pkg::INDEX_W-1:0]    position;
    logic                            is_last;

    int             idle_pct = 0;
    int             stall_pct = 0;
    bit             hold_req = 1'b0;
    int             hold_left = 0;
    int unsigned    cycles = 0;
    perm_scoreboard sb = new();

    unique_random_index_drawer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .range_count (range_count),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .random_word (random_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .index_value (index_value),
        .position    (position),
        .is_last     (is_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: checks each taken result, stalls at random or for a long hold.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_draw(index_value, position, is_last);
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic set_idle(input idle_mode_t mode);
        idle_pct  = (mode == IDLE_SENDER)   ? 74 : (mode == IDLE_BOTH) ? 14 : 0;
        stall_pct = (mode == IDLE_RECEIVER) ? 74 : (mode == IDLE_BOTH) ? 14 : 0;
    endtask

    // Writes the count; the block then clears its bitmap before taking words.
    task automatic write_count(input logic [urid_pkg::COUNT_W-1:0] count);
        cfg_valid <= 1'b1;
        range_count <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.start_run(count);
    endtask

    // Offers one word after an optional random gap and waits for acceptance.
    task automatic send_word(input logic [urid_pkg::WORD_W-1:0] word, output bit live);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        random_word <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        live = sb.note_word(word);
    endtask

    // Lets every predicted result arrive, then the tail of a dropped word.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_draws.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // One permutation run: mostly words aimed at fresh indices, some rejected
    // and some fully random, then a few words after completion.
    task automatic run_phase(input logic [urid_pkg::COUNT_W-1:0] count, input int budget,
                             input idle_mode_t mode, input int pause_at, input bit hold,
                             inout int used);
        int sent;
        int pick;
        bit live;
        settle();
        set_idle(mode);
        write_count(count);
        sent = 0;
        while (sent < budget && !sb.complete())
        begin
            pick = $urandom_range(99);
            send_word((pick < 70) ? sb.fresh_word() :
                      (pick < 80) ? sb.rejected_word() : $urandom, live);
            if (live)
                sent++;
            if (hold && sent == 1)
                hold_req = 1'b1;
            // Sender waits here until the block has delivered everything.
            if (sent == pause_at)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending_draws.size() != 0);
            end
        end
        if (sb.complete())
            repeat ($urandom_range(3, 1))
                send_word($urandom, live);
        used += sent;
    endtask

    initial
    begin
        int                           used;
        int                           phase;
        bit                           live;
        logic [urid_pkg::COUNT_W-1:0] count;

        set_idle(IDLE_NONE);
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // Count zero after reset: every word is ignored.
        send_word(32'h0000_0000, live);
        send_word(32'hFFFF_FFFF, live);

        // Count one: the first word yields index 0 and completes the run.
        settle();
        write_count(11'd1);
        send_word(32'hFFFF_FFFF, live);
        send_word(32'h0000_0000, live);

        // Count above the bound saturates to the full range; repeats are dropped.
        settle();
        write_count(11'h7FF);
        send_word(32'h0000_0000, live);
        send_word(32'hFFFF_FFFF, live);
        send_word(32'h0000_0400, live);
        send_word(32'h8000_03FF, live);
        send_word(32'h1234_5678, live);

        // Count three: word 0 falls below the rejection floor of 1.
        settle();
        write_count(11'd3);
        send_word(32'h0000_0000, live);
        send_word(32'h0000_0001, live);
        send_word(32'h0000_0002, live);
        send_word(32'h0000_0003, live);
        send_word(32'hFFFF_FFFF, live);

        // Count 1000: the floor is 296, so the edges of the rejected band.
        settle();
        write_count(11'd1000);
        send_word(32'd295, live);
        send_word(32'd296, live);
        send_word(32'hFFFF_FFFF, live);

        // Full range with a long receiver hold, then a pause on the sender side.
        used = 0;
        run_phase(11'd1024, 120, IDLE_NONE, -1, 1'b1, used);
        run_phase(11'd24, 60, IDLE_SENDER, 10, 1'b0, used);

        // Random runs, mostly short counts, rotating through the idling modes.
        phase = 0;
        while (used < RANDOM_WORDS)
        begin
            case ($urandom_range(9))
                0:       count = 11'd0;
                1:       count = 11'd1;
                2:       count = 11'd2;
                3:       count = urid_pkg::COUNT_W'($urandom_range(2047, 1025));
                4:       count = 11'd1024;
                default: count = urid_pkg::COUNT_W'($urandom_range(40, 3));
            endcase
            run_phase(count, (count >= 1024) ? 60 : 4 * count + 8,
                      idle_mode_t'(phase % 4), -1, 1'b0, used);
            phase++;
        end

        settle();
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/urid_pkg.sv
sv/urid_ram.sv
sv/urid_ctrl.sv
sv/urid_dp.sv
sv/unique_random_index_drawer.sv
dv/tb_unique_random_index_drawer.sv
